[src/totp_pkg.sv]
// Package for the TOTP code generator: SHA-1 constants, round functions and defaults.
// Used by totp_sha1_core, the top level and the testbench; depends on nothing.
package totp_pkg;

   localparam int KeyBytesDefault    = 64;
   localparam int StepSecondsDefault = 30;
   localparam int CodeDigitsDefault  = 6;

   localparam int KeyWords     = 8;
   localparam int KeyIdxWidth  = 3;
   localparam int KeyWidth     = 64;
   localparam int CodeWidth    = 20;
   localparam int LeftWidth    = 5;

   localparam logic [7:0] IpadByte = 8'h36;
   localparam logic [7:0] OpadByte = 8'h5C;

   localparam logic [159:0] ShaInit =
      160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

   // Round constant for one SHA-1 round.
   function automatic logic [31:0] round_const(input logic [6:0] rnd);
      logic [31:0] k;
      if (rnd < 7'd20)      k = 32'h5A827999;
      else if (rnd < 7'd40) k = 32'h6ED9EBA1;
      else if (rnd < 7'd60) k = 32'h8F1BBCDC;
      else                  k = 32'hCA62C1D6;
      return k;
   endfunction

   // Boolean function for one SHA-1 round.
   function automatic logic [31:0] round_func(input logic [6:0] rnd, input logic [31:0] b,
                                              input logic [31:0] c, input logic [31:0] d);
      logic [31:0] f;
      if (rnd < 7'd20)      f = (b & c) | (~b & d);
      else if (rnd < 7'd40) f = b ^ c ^ d;
      else if (rnd < 7'd60) f = (b & c) | (b & d) | (c & d);
      else                  f = b ^ c ^ d;
      return f;
   endfunction

endpackage

[src/totp_sha1_core.sv]
// Iterative SHA-1 compression: one round per cycle over a 16-word message window.
// Depends on totp_pkg.
module totp_sha1_core (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [159:0]   hash_in,
   input  logic [511:0]   block_in,
   output logic           done,
   output logic [159:0]   hash_out
);

   logic [31:0]  w_ff [16];
   logic [31:0]  w_in [16];
   logic [31:0]  a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0]  a_in, b_in, c_in, d_in, e_in;
   logic [159:0] h_ff, h_in;
   logic [6:0]   rnd_ff, rnd_in;
   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic [31:0]  w_new, temp;

   // One round of the compression and one step of the schedule window.
   always_comb begin
      w_new = w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0];
      w_new = {w_new[30:0], w_new[31]};
      temp  = {a_ff[26:0], a_ff[31:27]} + totp_pkg::round_func(rnd_ff, b_ff, c_ff, d_ff)
              + e_ff + totp_pkg::round_const(rnd_ff) + w_ff[0];
      a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff; e_in = e_ff;
      h_in = h_ff; rnd_in = rnd_ff; busy_in = busy_ff; done_in = 1'b0;
      for (int i = 0; i < 16; i++) w_in[i] = w_ff[i];
      if (start) begin
         for (int i = 0; i < 16; i++) w_in[i] = block_in[511 - 32*i -: 32];
         {a_in, b_in, c_in, d_in, e_in} = hash_in;
         h_in    = hash_in;
         rnd_in  = 7'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         for (int i = 0; i < 15; i++) w_in[i] = w_ff[i+1];
         w_in[15] = w_new;
         e_in = d_ff; d_in = c_ff; c_in = {b_ff[1:0], b_ff[31:2]}; b_in = a_ff; a_in = temp;
         rnd_in = rnd_ff + 7'd1;
         if (rnd_ff == 7'd79) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         rnd_ff  <= 7'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         rnd_ff  <= rnd_in;
      end
      a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; d_ff <= d_in; e_ff <= e_in;
      h_ff <= h_in;
      for (int i = 0; i < 16; i++) w_ff[i] <= w_in[i];
   end

   assign done = done_ff;
   assign hash_out = {h_ff[159:128] + a_ff, h_ff[127:96] + b_ff, h_ff[95:64] + c_ff,
                      h_ff[63:32] + d_ff, h_ff[31:0] + e_ff};

   // The core is never restarted in the middle of a compression.
   assert property (@(posedge clock) disable iff (reset) busy_ff |-> !start)
      else $error("sha1 core restarted while busy");
   // Done follows the last round.
   assert property (@(posedge clock) disable iff (reset)
      (busy_ff && rnd_ff == 7'd79 && !start) |=> done_ff)
      else $error("sha1 core missed done");
   assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff)
      else $error("sha1 core done while busy");

endmodule

[src/totp_divider.sv]
// Shared constant divider: reciprocal estimate, multiply back and one correction step.
// Takes a dividend below 2^31 and floor(2^31 / divisor); depends on nothing.
module totp_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   input  logic [31:0] recip,
   output logic        done,
   output logic [31:0] quotient,
   output logic [31:0] remainder
);

   typedef enum logic [1:0] {
      P_IDLE, P_EST, P_BACK, P_FIX
   } phase_type;

   phase_type   phase_ff;
   logic [31:0] x_ff, d_ff, recip_ff, q_ff, r_ff;
   logic        done_ff;
   logic [31:0] mul_a, mul_b;
   logic [63:0] product;

   // One multiplier serves both the quotient estimate and the multiply back.
   always_comb begin
      mul_a   = (phase_ff == P_EST) ? x_ff : q_ff;
      mul_b   = (phase_ff == P_EST) ? recip_ff : d_ff;
      product = mul_a * mul_b;
   end

   // The estimate is the true quotient or one below it, so one correction suffices.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= P_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (phase_ff)
            P_IDLE: if (start) begin
               x_ff     <= dividend;
               d_ff     <= divisor;
               recip_ff <= recip;
               phase_ff <= P_EST;
            end
            P_EST: begin
               q_ff     <= product[62:31];
               phase_ff <= P_BACK;
            end
            P_BACK: begin
               r_ff     <= x_ff - product[31:0];
               phase_ff <= P_FIX;
            end
            P_FIX: begin
               if (r_ff >= d_ff) begin
                  r_ff <= r_ff - d_ff;
                  q_ff <= q_ff + 32'd1;
               end
               done_ff  <= 1'b1;
               phase_ff <= P_IDLE;
            end
            default: phase_ff <= P_IDLE;
         endcase
      end
   end

   assign done      = done_ff;
   assign quotient  = q_ff;
   assign remainder = r_ff;

   // The divider is never restarted while it works.
   assert property (@(posedge clock) disable iff (reset) (phase_ff != P_IDLE) |-> !start)
      else $error("divider restarted while busy");
   assert property (@(posedge clock) disable iff (reset) done_ff |-> (phase_ff == P_IDLE))
      else $error("divider done while busy");
   // Before the correction the remainder is below twice the divisor.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == P_FIX) |-> ({1'b0, r_ff} < {d_ff, 1'b0}))
      else $error("divider estimate out of range");
   assert property (@(posedge clock) disable iff (reset) done_ff |-> (r_ff < d_ff))
      else $error("divider remainder out of range");

endmodule

[src/totp_code_generator.sv]
// Top level of the TOTP code generator: key registers, sequencer, truncation.
// Depends on totp_pkg, totp_sha1_core and totp_divider.
//
// Usage: write the key into csr index 0..7 (64 bits each, byte 0 in the top
// bits) while idle. Send a Unix time on req_*; one item comes back on rsp_*
// carrying the six-digit code and the seconds left in the window.
// The time is divided by the step in four 16-bit digits in the shared
// reciprocal divider, four SHA-1 compressions run in the round unit, and the
// truncated digest is reduced modulo 10^digits in the divider.
// One item is worked on at a time; req_tready is low from acceptance until
// the result is taken, so a new item is accepted only once the last result
// has gone, and any wait on rsp_tready delays it. A stalled result holds in
// its output register.
// Reset clears the key to zero and returns the sequencer to idle; it is
// synchronous.
module totp_code_generator #(
   parameter int KEY_BYTES    = totp_pkg::KeyBytesDefault,
   parameter int STEP_SECONDS = totp_pkg::StepSecondsDefault,
   parameter int CODE_DIGITS  = totp_pkg::CodeDigitsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [63:0] unix_time
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [19:0] code, [24:20] seconds_left, rest zero
   input  logic        csr_wen,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   localparam logic [63:0] ModValue  = 64'(10 ** CODE_DIGITS);
   localparam logic [31:0] ModRecip  = 32'((64'd1 << 31) / ModValue);
   localparam logic [31:0] StepValue = 32'(STEP_SECONDS);
   localparam logic [31:0] StepRecip = 32'((64'd1 << 31) / 64'(STEP_SECONDS));

   typedef enum logic [3:0] {
      S_IDLE, S_DIV, S_DIV_WAIT, S_HASH, S_HASH_WAIT, S_MOD, S_MOD_WAIT, S_OUT
   } state_type;

   state_type    state_ff;
   logic [63:0]  key_ff [totp_pkg::KeyWords];
   logic [511:0] key_blk;
   logic [1:0]   pass_ff;
   logic [159:0] hash_ff, inner_ff;
   logic [63:0]  counter_ff;
   logic [63:0]  time_ff;
   logic [1:0]   digit_ff;
   logic [15:0]  rem_ff;
   logic [4:0]   left_ff;
   logic [31:0]  bin_ff;
   logic [19:0]  code_ff;
   logic         sha_start, div_start, sha_done, div_done;
   logic [159:0] sha_hash_out;
   logic [511:0] sha_block;
   logic [31:0]  div_dividend, div_divisor, div_recip, div_q, div_r;
   logic [511:0] pad_blk;
   logic [7:0]   pad_byte;
   logic [3:0]   offset;
   logic [31:0]  trunc;
   logic [159:0] dig;

   // Key bytes beyond KEY_BYTES count as zero.
   always_comb begin
      for (int i = 0; i < 64; i++) begin
         if (i < KEY_BYTES) key_blk[511 - 8*i -: 8] = key_ff[i/8][63 - 8*(i%8) -: 8];
         else               key_blk[511 - 8*i -: 8] = 8'h00;
      end
   end

   // Block for the current pass: ipad key, inner tail, opad key, outer tail.
   always_comb begin
      pad_byte = (pass_ff[1] == 1'b0) ? totp_pkg::IpadByte : totp_pkg::OpadByte;
      pad_blk  = key_blk ^ {64{pad_byte}};
      unique case (pass_ff)
         2'd0, 2'd2: sha_block = pad_blk;
         2'd1: sha_block = {counter_ff, 8'h80, 376'd0, 64'd576};
         default: sha_block = {inner_ff, 8'h80, 280'd0, 64'd672};
      endcase
   end

   // Dynamic truncation of the digest that the last pass produces.
   always_comb begin
      dig    = sha_hash_out;
      offset = dig[3:0];
      trunc  = dig[159 - 8*offset -: 32];
      trunc[31] = 1'b0;
   end

   // The time is divided 16 bits at a time, carrying the partial remainder.
   assign sha_start    = (state_ff == S_HASH);
   assign div_start    = (state_ff == S_DIV) || (state_ff == S_MOD);
   assign div_dividend = (state_ff == S_MOD) ? bin_ff
                                             : {rem_ff, time_ff[63 - 16*digit_ff -: 16]};
   assign div_divisor  = (state_ff == S_MOD) ? ModValue[31:0] : StepValue;
   assign div_recip    = (state_ff == S_MOD) ? ModRecip : StepRecip;

   totp_sha1_core u_sha (
      .clock(clock), .reset(reset), .start(sha_start),
      .hash_in((pass_ff[0] == 1'b0) ? totp_pkg::ShaInit : hash_ff),
      .block_in(sha_block), .done(sha_done), .hash_out(sha_hash_out)
   );

   totp_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_dividend),
      .divisor(div_divisor), .recip(div_recip), .done(div_done), .quotient(div_q),
      .remainder(div_r)
   );

   // Sequencer and registered result.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pass_ff  <= 2'd0;
         for (int i = 0; i < totp_pkg::KeyWords; i++) key_ff[i] <= '0;
      end else begin
         if (csr_wen) key_ff[csr_index] <= csr_wdata;
         unique case (state_ff)
            S_IDLE: if (req_tvalid) begin
               time_ff  <= req_tdata;
               digit_ff <= 2'd0;
               rem_ff   <= 16'd0;
               state_ff <= S_DIV;
            end
            S_DIV: state_ff <= S_DIV_WAIT;
            S_DIV_WAIT: if (div_done) begin
               counter_ff <= {counter_ff[47:0], div_q[15:0]};
               rem_ff     <= div_r[15:0];
               if (digit_ff == 2'd3) begin
                  left_ff  <= 5'(StepValue - div_r);
                  pass_ff  <= 2'd0;
                  state_ff <= S_HASH;
               end else begin
                  digit_ff <= digit_ff + 2'd1;
                  state_ff <= S_DIV;
               end
            end
            S_HASH: state_ff <= S_HASH_WAIT;
            S_HASH_WAIT: if (sha_done) begin
               hash_ff <= sha_hash_out;
               if (pass_ff == 2'd1) inner_ff <= sha_hash_out;
               if (pass_ff == 2'd3) begin
                  bin_ff   <= trunc;
                  state_ff <= S_MOD;
               end else begin
                  pass_ff  <= pass_ff + 2'd1;
                  state_ff <= S_HASH;
               end
            end
            S_MOD: state_ff <= S_MOD_WAIT;
            S_MOD_WAIT: if (div_done) begin
               code_ff  <= div_r[19:0];
               state_ff <= S_OUT;
            end
            S_OUT: if (rsp_tready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {7'd0, left_ff, code_ff};

   // The request side is closed while an item is in flight.
   assert property (@(posedge clock) disable iff (reset) rsp_tvalid |-> !req_tready)
      else $error("request taken during result");
   // An accepted item starts the counter division.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_DIV))
      else $error("accept did not start work");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
      else $error("result dropped");

endmodule

[dv/totp_code_generator_tb.sv]
// Testbench for totp_code_generator: drives Unix times, predicts each six-digit
// code and the seconds left with a behavioral HMAC-SHA1 TOTP model, and checks them.
// Depends on totp_pkg and the totp_code_generator RTL.
`timescale 1ns / 1ps

module totp_code_generator_tb;

   localparam int LimitCycles = 3_000_000;
   localparam int DrainCycles = 600;

   typedef struct packed {
      logic [totp_pkg::CodeWidth-1:0] code;
      logic [totp_pkg::LeftWidth-1:0] seconds_left;
   } totp_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        csr_wen;
   logic [2:0]  csr_index;
   logic [63:0] csr_wdata;

   logic [63:0]     key_regs [totp_pkg::KeyWords];
   logic [63:0]     pending_times [$];
   totp_result_type expected_codes [$];
   logic            req_taken;
   int              failures = 0;
   int              cycle_count = 0;
   int              req_gap;
   int              rsp_gap;

   totp_code_generator uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wen(csr_wen), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] rol(input logic [31:0] x, input int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   // One SHA-1 compression of a 512-bit block, byte 0 in the top bits.
   function automatic logic [159:0] sha1_compress(input logic [159:0] hin,
                                                  input logic [511:0] blk);
      logic [31:0] w [80];
      logic [31:0] a, b, c, d, e, f, k, t;
      for (int i = 0; i < 16; i++) w[i] = blk[511 - 32*i -: 32];
      for (int i = 16; i < 80; i++) w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
      {a, b, c, d, e} = hin;
      for (int i = 0; i < 80; i++) begin
         if (i < 20) begin f = (b & c) | (~b & d); k = 32'h5A827999; end
         else if (i < 40) begin f = b ^ c ^ d; k = 32'h6ED9EBA1; end
         else if (i < 60) begin f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC; end
         else begin f = b ^ c ^ d; k = 32'hCA62C1D6; end
         t = rol(a, 5) + f + e + k + w[i];
         e = d; d = c; c = rol(b, 30); b = a; a = t;
      end
      return {hin[159:128] + a, hin[127:96] + b, hin[95:64] + c,
              hin[63:32] + d, hin[31:0] + e};
   endfunction

   // Expected code and seconds left for one Unix time under the current key.
   function automatic totp_result_type predict_code(input logic [63:0] unix_time);
      logic [511:0] key_block, tail;
      logic [159:0] inner, digest;
      logic [63:0]  counter;
      logic [31:0]  truncated;
      logic [3:0]   offset;
      totp_result_type r;
      for (int i = 0; i < totp_pkg::KeyWords; i++) key_block[511 - 64*i -: 64] = key_regs[i];
      counter = unix_time / 64'(totp_pkg::StepSecondsDefault);
      // Inner hash: key xor ipad, then the counter with padding for 72 bytes.
      tail = '0;
      tail[511 -: 64] = counter;
      tail[447 -: 8] = 8'h80;
      tail[63:0] = 64'd576;
      inner = sha1_compress(sha1_compress(totp_pkg::ShaInit,
                                          key_block ^ {64{totp_pkg::IpadByte}}), tail);
      // Outer hash: key xor opad, then the inner digest for 84 bytes.
      tail = '0;
      tail[511 -: 160] = inner;
      tail[351 -: 8] = 8'h80;
      tail[63:0] = 64'd672;
      digest = sha1_compress(sha1_compress(totp_pkg::ShaInit,
                                           key_block ^ {64{totp_pkg::OpadByte}}), tail);
      // Dynamic truncation on the low nibble of the last digest byte.
      offset = digest[3:0];
      truncated = digest[159 - 8*offset -: 32];
      truncated[31] = 1'b0;
      r.code = totp_pkg::CodeWidth'(truncated % 32'd1000000);
      r.seconds_left = totp_pkg::LeftWidth'(64'(totp_pkg::StepSecondsDefault)
                       - unix_time % 64'(totp_pkg::StepSecondsDefault));
      return r;
   endfunction

   // Driver: presents pending times with random gaps between items.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_gap <= 0;
      end else if (req_tvalid && !req_taken) begin
         req_tvalid <= 1'b1;
      end else if (req_gap > 0) begin
         req_tvalid <= 1'b0;
         req_gap <= req_gap - 1;
      end else if (pending_times.size() > 0) begin
         req_tvalid <= 1'b1;
         req_tdata <= pending_times.pop_front();
         req_gap <= $urandom_range(0, 1) ? 0 : $urandom_range(0, 16);
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // The item in flight leaves the driver once accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            expected_codes.push_back(predict_code(req_tdata));
         end
      end
   end

   // Receiver back-pressure drawn per result.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_gap <= 0;
      end else if (rsp_gap > 0) begin
         rsp_tready <= 1'b0;
         rsp_gap <= rsp_gap - 1;
      end else if (rsp_tready && rsp_tvalid) begin
         rsp_tready <= 1'b0;
         rsp_gap <= $urandom_range(0, 1) ? 0 : $urandom_range(0, 16);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: compares each accepted result with the oldest expectation.
   always @(posedge clock) begin
      totp_result_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_codes.size() == 0) begin
            $error("unexpected result item: rsp_tdata=%h", rsp_tdata);
            failures++;
         end else begin
            exp_r = expected_codes.pop_front();
            if (rsp_tdata[19:0] !== exp_r.code) begin
               $error("code: expected %0d, actual %0d", exp_r.code, rsp_tdata[19:0]);
               failures++;
            end
            if (rsp_tdata[24:20] !== exp_r.seconds_left) begin
               $error("seconds_left: expected %0d, actual %0d",
                      exp_r.seconds_left, rsp_tdata[24:20]);
               failures++;
            end
            if (rsp_tdata[31:25] !== 7'd0) begin
               $error("rsp_tdata pad: expected 0, actual %h", rsp_tdata[31:25]);
               failures++;
            end
         end
      end
   end

   // Watchdog on total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LimitCycles) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Waits until the driver is empty and every expected result has arrived.
   task automatic wait_idle();
      while (pending_times.size() > 0 || req_tvalid || expected_codes.size() > 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // Writes one key register at a falling edge.
   task automatic write_key(input logic [2:0] idx, input logic [63:0] value);
      @(negedge clock);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      key_regs[idx] = value;
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   task automatic load_key(input int mode);
      for (int i = 0; i < totp_pkg::KeyWords; i++) begin
         case (mode)
            0: write_key(3'(i), '0);
            1: write_key(3'(i), '1);
            2: write_key(3'(i), (i < 2) ? {$urandom, $urandom} : 64'd0);
            default: write_key(3'(i), {$urandom, $urandom});
         endcase
      end
   endtask

   function automatic logic [63:0] random_time();
      case ($urandom_range(0, 3))
         0: return {$urandom, $urandom};
         1: return 64'($urandom_range(0, 100));
         2: return {32'd0, $urandom};
         default: return 64'd1700000000 + $urandom_range(0, 100000);
      endcase
   endfunction

   initial begin
      reset = 1'b1;
      csr_wen = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      for (int i = 0; i < totp_pkg::KeyWords; i++) key_regs[i] = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: reset key, then time extremes and window edges.
      pending_times.push_back(64'd0);
      pending_times.push_back(64'd29);
      pending_times.push_back(64'd30);
      pending_times.push_back(64'd59);
      pending_times.push_back('1);
      pending_times.push_back(64'hFFFF_FFFF_FFFF_FFE1);
      pending_times.push_back(64'h5555_5555_5555_5555);
      pending_times.push_back(64'hAAAA_AAAA_AAAA_AAAA);
      pending_times.push_back(64'd59);
      pending_times.push_back(64'd1111111109);
      wait_idle();

      // All-ones key, then a short key padded with zeros.
      load_key(1);
      pending_times.push_back(64'd0);
      pending_times.push_back('1);
      pending_times.push_back(64'd1234567890);
      wait_idle();
      write_key(3'd0, 64'h3132333435363738);
      write_key(3'd1, 64'h3930313233343536);
      write_key(3'd2, 64'h3738393000000000);
      for (int i = 3; i < totp_pkg::KeyWords; i++) write_key(3'(i), '0);
      pending_times.push_back(64'd59);
      pending_times.push_back(64'd1111111109);
      pending_times.push_back(64'd2000000000);
      wait_idle();

      // Random phases over several key settings.
      for (int ph = 0; ph < 6; ph++) begin
         load_key(ph == 5 ? 0 : (ph == 4 ? 1 : ($urandom_range(0, 1) ? 2 : 3)));
         for (int n = 0; n < 250; n++) pending_times.push_back(random_time());
         wait_idle();
      end

      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

[sim.f]
src/totp_pkg.sv
src/totp_sha1_core.sv
src/totp_divider.sv
src/totp_code_generator.sv
dv/totp_code_generator_tb.sv
